// ===== rtl/core/selective_repeat_receiver_window_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion helpers for the selective-repeat receiver window.
// Each macro places one labeled concurrent assertion on the given clock.
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_RECEIVER_WINDOW_ASSERT_SVH
`define SELECTIVE_REPEAT_RECEIVER_WINDOW_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRRW_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SRRW_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/srrw_pkg.sv =====
// ----------------------------------------------------------------------------
// srrw_pkg
// Shared constants, codes and types of the selective-repeat receiver window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srrw_pkg;

  // Window geometry and field widths.
  localparam int WINDOW       = 4;
  localparam int SEQ_SPACE    = 8;
  localparam int PAYLOAD_BITS = 32;
  localparam int SEQ_W        = 3;
  localparam int SLOT_W       = 2;
  localparam int MODE_W       = 2;
  localparam int KIND_W       = 2;
  localparam int CNT_W        = $clog2(WINDOW + 1);

  // Mode register codes; the unused code behaves as plain ACK mode.
  localparam logic [MODE_W-1:0] MODE_ACK   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NACK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PIGGY = 2'd2;

  // Result kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_ACK     = 2'd0,
    KIND_NACK    = 2'd1,
    KIND_DELIVER = 2'd2
  } kind_e;

  // Operations of the shared modulo unit.
  typedef enum logic {
    ALU_SUB = 1'b0,
    ALU_INC = 1'b1
  } alu_op_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_CLASSIFY = 2'd1,
    ST_EMIT     = 2'd2
  } state_e;

  // Control from the sequencer to the slot store.
  typedef struct packed {
    logic                    wr_en;
    logic [SLOT_W-1:0]       wr_slot;
    logic [PAYLOAD_BITS-1:0] wr_data;
    logic                    clr_en;
    logic [SLOT_W-1:0]       clr_slot;
    logic [SLOT_W-1:0]       rd_slot;
    logic [SLOT_W-1:0]       look_slot;
  } store_req_t;

  // Status from the slot store back to the sequencer.
  typedef struct packed {
    logic [PAYLOAD_BITS-1:0] rd_data;
    logic                    look_mark;
  } store_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/srrw_if.sv =====
// ----------------------------------------------------------------------------
// srrw_if
// Valid/ready channels of the receiver window: frames, results, mode writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// Arriving data frame.
interface srrw_frame_if;
  logic                              valid;
  logic                              ready;
  logic [srrw_pkg::SEQ_W-1:0]        seq_num;
  logic [srrw_pkg::PAYLOAD_BITS-1:0] payload;

  modport source (output valid, output seq_num, output payload, input ready);
  modport sink   (input valid, input seq_num, input payload, output ready);
endinterface

// ACK, NACK or delivery result.
interface srrw_result_if;
  logic                              valid;
  logic                              ready;
  logic [srrw_pkg::KIND_W-1:0]       kind;
  logic [srrw_pkg::SEQ_W-1:0]        number;
  logic [srrw_pkg::PAYLOAD_BITS-1:0] data_out;
  logic                              with_data;
  logic                              last;

  modport source (output valid, output kind, output number, output data_out,
                  output with_data, output last, input ready);
  modport sink   (input valid, input kind, input number, input data_out,
                  input with_data, input last, output ready);
endinterface

// Mode register write.
interface srrw_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [srrw_pkg::MODE_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/srrw_alu.sv =====
// ----------------------------------------------------------------------------
// srrw_alu
// Shared modulo unit: distance of a sequence number from the base, or the
// successor of the base, both within the sequence space.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srrw_alu (
  input  srrw_pkg::alu_op_e                op_i,
  input  logic [srrw_pkg::SEQ_W-1:0]       a_i,
  input  logic [srrw_pkg::SEQ_W-1:0]       b_i,
  output logic [srrw_pkg::SEQ_W-1:0]       res_o
);

  localparam int XW = srrw_pkg::SEQ_W + 1;
  localparam logic [XW-1:0] SpaceX = XW'(srrw_pkg::SEQ_SPACE);

  logic [XW-1:0] addend;
  logic [XW-1:0] sum;

  // One add followed by one compare-and-subtract wrap.
  always_comb begin
    case (op_i)
      srrw_pkg::ALU_SUB: addend = SpaceX - {1'b0, b_i};
      srrw_pkg::ALU_INC: addend = XW'(1);
      default:           addend = '0;
    endcase
    sum = {1'b0, a_i} + addend;
    if (sum >= SpaceX) begin
      sum = sum - SpaceX;
    end
    res_o = sum[srrw_pkg::SEQ_W-1:0];
  end

endmodule

`default_nettype wire

// ===== rtl/core/srrw_store.sv =====
// ----------------------------------------------------------------------------
// srrw_store
// Per-slot received marks and buffered payload words of the window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srrw_store (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  srrw_pkg::store_req_t req_i,
  output srrw_pkg::store_rsp_t rsp_o
);

  logic [srrw_pkg::WINDOW-1:0]       marks_q;
  logic [srrw_pkg::PAYLOAD_BITS-1:0] data_q [srrw_pkg::WINDOW];

  // Received marks: set on a buffered frame, cleared on delivery.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marks_q <= '0;
    end else begin
      if (req_i.wr_en) begin
        marks_q[req_i.wr_slot] <= 1'b1;
      end
      if (req_i.clr_en) begin
        marks_q[req_i.clr_slot] <= 1'b0;
      end
    end
  end

  // Payload words need no reset; a slot is read only after it was marked.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      data_q[req_i.wr_slot] <= req_i.wr_data;
    end
  end

  // Read the slot at the base and look ahead at the mark of the next slot.
  assign rsp_o.rd_data   = data_q[req_i.rd_slot];
  assign rsp_o.look_mark = marks_q[req_i.look_slot];

endmodule

`default_nettype wire

// ===== rtl/core/srrw_ctrl.sv =====
// ----------------------------------------------------------------------------
// srrw_ctrl
// Sequencer of the receiver window: classifies a frame against the window,
// then emits its ACK, NACK and in-order deliveries one per output cycle while results are taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "selective_repeat_receiver_window_assert.svh"

module srrw_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Mode register write.
  input  logic                              cfg_valid_i,
  input  logic [srrw_pkg::MODE_W-1:0]       cfg_data_i,
  // Frame request.
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [srrw_pkg::SEQ_W-1:0]        in_seq_i,
  input  logic [srrw_pkg::PAYLOAD_BITS-1:0] in_payload_i,
  // Result request.
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [srrw_pkg::KIND_W-1:0]       out_kind_o,
  output logic [srrw_pkg::SEQ_W-1:0]        out_number_o,
  output logic [srrw_pkg::PAYLOAD_BITS-1:0] out_data_o,
  output logic                              out_with_data_o,
  output logic                              out_last_o,
  // Shared modulo unit.
  output srrw_pkg::alu_op_e                 alu_op_o,
  output logic [srrw_pkg::SEQ_W-1:0]        alu_a_o,
  output logic [srrw_pkg::SEQ_W-1:0]        alu_b_o,
  input  logic [srrw_pkg::SEQ_W-1:0]        alu_res_i,
  // Slot store.
  output srrw_pkg::store_req_t              store_req_o,
  input  srrw_pkg::store_rsp_t              store_rsp_i
);

  localparam int XW = srrw_pkg::SEQ_W + 1;
  localparam logic [XW-1:0] WinX    = XW'(srrw_pkg::WINDOW);
  localparam logic [XW-1:0] BehindX = XW'(srrw_pkg::SEQ_SPACE - srrw_pkg::WINDOW);
  localparam logic [srrw_pkg::CNT_W-1:0] CntLast = srrw_pkg::CNT_W'(srrw_pkg::WINDOW - 1);

  srrw_pkg::state_e                  state_q, state_d;
  logic [srrw_pkg::MODE_W-1:0]       mode_q;
  logic [srrw_pkg::SEQ_W-1:0]        seq_q, seq_d;
  logic [srrw_pkg::PAYLOAD_BITS-1:0] payload_q, payload_d;
  logic [srrw_pkg::SEQ_W-1:0]        base_q, base_d;
  logic                              nack_pend_q, nack_pend_d;
  logic [srrw_pkg::CNT_W-1:0]        dcnt_q, dcnt_d;
  logic                              out_valid_q, out_valid_d;
  srrw_pkg::kind_e                   out_kind_q, out_kind_d;
  logic [srrw_pkg::SEQ_W-1:0]        out_number_q, out_number_d;
  logic [srrw_pkg::PAYLOAD_BITS-1:0] out_data_q, out_data_d;
  logic                              out_wd_q, out_wd_d;
  logic                              out_last_q, out_last_d;

  logic in_fire;
  logic out_fire;
  logic in_win;
  logic behind;
  logic piggy;
  logic nack_mode;

  assign in_fire   = in_valid_i && in_ready_o;
  assign out_fire  = out_valid_q && out_ready_i;
  assign piggy     = (mode_q == srrw_pkg::MODE_PIGGY);
  assign nack_mode = (mode_q == srrw_pkg::MODE_NACK);
  assign in_win    = ({1'b0, alu_res_i} < WinX);
  assign behind    = ({1'b0, alu_res_i} >= BehindX);

  // Mode register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= srrw_pkg::MODE_ACK;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srrw_pkg::ST_IDLE;
      base_q      <= '0;
      nack_pend_q <= 1'b0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      base_q      <= base_d;
      nack_pend_q <= nack_pend_d;
      dcnt_q      <= dcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Frame and result payload registers.
  always_ff @(posedge clk_i) begin
    seq_q        <= seq_d;
    payload_q    <= payload_d;
    out_kind_q   <= out_kind_d;
    out_number_q <= out_number_d;
    out_data_q   <= out_data_d;
    out_wd_q     <= out_wd_d;
    out_last_q   <= out_last_d;
  end

  // Next state, shared unit operands and store control.
  always_comb begin
    state_d      = state_q;
    seq_d        = seq_q;
    payload_d    = payload_q;
    base_d       = base_q;
    nack_pend_d  = nack_pend_q;
    dcnt_d       = dcnt_q;
    out_valid_d  = out_valid_q;
    out_kind_d   = out_kind_q;
    out_number_d = out_number_q;
    out_data_d   = out_data_q;
    out_wd_d     = out_wd_q;
    out_last_d   = out_last_q;
    in_ready_o   = 1'b0;

    alu_op_o = srrw_pkg::ALU_INC;
    alu_a_o  = base_q;
    alu_b_o  = base_q;

    store_req_o.wr_en     = 1'b0;
    store_req_o.wr_slot   = seq_q[srrw_pkg::SLOT_W-1:0];
    store_req_o.wr_data   = payload_q;
    store_req_o.clr_en    = 1'b0;
    store_req_o.clr_slot  = base_q[srrw_pkg::SLOT_W-1:0];
    store_req_o.rd_slot   = base_q[srrw_pkg::SLOT_W-1:0];
    store_req_o.look_slot = alu_res_i[srrw_pkg::SLOT_W-1:0];

    case (state_q)
      // Wait for a frame.
      srrw_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_fire) begin
          seq_d     = in_seq_i;
          payload_d = in_payload_i;
          state_d   = srrw_pkg::ST_CLASSIFY;
        end
      end

      // Place the frame against the window and prepare its ACK.
      srrw_pkg::ST_CLASSIFY: begin
        alu_op_o     = srrw_pkg::ALU_SUB;
        alu_a_o      = seq_q;
        out_kind_d   = srrw_pkg::KIND_ACK;
        out_number_d = seq_q;
        out_data_d   = '0;
        out_wd_d     = piggy;
        dcnt_d       = '0;
        if (in_win) begin
          // A frame off the base leaves the base slot empty: no delivery.
          store_req_o.wr_en = 1'b1;
          nack_pend_d       = nack_mode && (alu_res_i != '0);
          out_last_d        = (alu_res_i != '0) && !nack_mode;
          out_valid_d       = 1'b1;
          state_d           = srrw_pkg::ST_EMIT;
        end else if (behind) begin
          nack_pend_d = 1'b0;
          out_last_d  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = srrw_pkg::ST_EMIT;
        end else begin
          state_d = srrw_pkg::ST_IDLE;
        end
      end

      // Hand out results; load the next one as the current one is taken.
      srrw_pkg::ST_EMIT: begin
        if (out_fire) begin
          if (out_last_q) begin
            out_valid_d = 1'b0;
            state_d     = srrw_pkg::ST_IDLE;
          end else if (nack_pend_q) begin
            nack_pend_d  = 1'b0;
            out_kind_d   = srrw_pkg::KIND_NACK;
            out_number_d = base_q;
            out_data_d   = '0;
            out_wd_d     = 1'b0;
            out_last_d   = 1'b1;
          end else begin
            // Deliver the base slot and advance the base through the unit.
            store_req_o.clr_en = 1'b1;
            out_kind_d   = srrw_pkg::KIND_DELIVER;
            out_number_d = base_q;
            out_data_d   = store_rsp_i.rd_data;
            out_wd_d     = 1'b0;
            out_last_d   = !store_rsp_i.look_mark || (dcnt_q == CntLast);
            base_d       = alu_res_i;
            dcnt_d       = dcnt_q + 1'b1;
          end
        end
      end

      default: begin
        state_d     = srrw_pkg::ST_IDLE;
        out_valid_d = 1'b0;
      end
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign out_kind_o      = out_kind_q;
  assign out_number_o    = out_number_q;
  assign out_data_o      = out_data_q;
  assign out_with_data_o = out_wd_q;
  assign out_last_o      = out_last_q;

  // A new frame is only taken once every result of the previous one is out.
  `SRRW_ASSERT_SAME(a_frame_after_results, clk_i, rst_ni, in_fire, !out_valid_q,
    "frame accepted while a result is pending")
  // A NACK always closes the results of its frame.
  `SRRW_ASSERT_SAME(a_nack_is_last, clk_i, rst_ni,
    out_valid_q && (out_kind_q == srrw_pkg::KIND_NACK), out_last_q,
    "NACK result not marked last")
  // Only an ACK may carry the piggyback flag.
  `SRRW_ASSERT_SAME(a_piggy_on_ack, clk_i, rst_ni, out_valid_q && out_wd_q,
    out_kind_q == srrw_pkg::KIND_ACK, "piggyback flag on a non-ACK result")
  // Taking the last result returns the sequencer to idle with nothing pending.
  `SRRW_ASSERT_NEXT(a_last_to_idle, clk_i, rst_ni, out_fire && out_last_q,
    (state_q == srrw_pkg::ST_IDLE) && !out_valid_q, "no return to idle after last")

endmodule

`default_nettype wire

// ===== rtl/core/selective_repeat_receiver_window.sv =====
// ----------------------------------------------------------------------------
// selective_repeat_receiver_window
// Selective-repeat ARQ receiver: buffers frames inside the window, answers
// with ACK or NACK requests and delivers buffered payloads in order.
// ----------------------------------------------------------------------------
// A frame request is taken when the block is idle. In the classify state the
// single shared modulo unit places it against the window base and its ACK is
// registered onto the result channel; a NACK of the base (ACK plus NACK mode) or
// the in-order deliveries follow one per cycle as long as results are taken. A
// new frame is taken only after the last result of the previous one, and a
// frame outside both the window and the duplicate range returns the block to
// idle with no result. The last result of each frame carries the last flag.
// Mode writes are taken at any time and are meant to happen while no frame is
// in progress.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module selective_repeat_receiver_window (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  srrw_frame_if.sink           frame_i,
  srrw_result_if.source        result_o,
  srrw_cfg_if.sink             cfg_i
);

  srrw_pkg::alu_op_e          alu_op;
  logic [srrw_pkg::SEQ_W-1:0] alu_a;
  logic [srrw_pkg::SEQ_W-1:0] alu_b;
  logic [srrw_pkg::SEQ_W-1:0] alu_res;
  srrw_pkg::store_req_t       store_req;
  srrw_pkg::store_rsp_t       store_rsp;

  // The mode register is always writable.
  assign cfg_i.ready = 1'b1;

  // Sequencer.
  srrw_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_i.valid),
    .cfg_data_i      (cfg_i.data),
    .in_valid_i      (frame_i.valid),
    .in_ready_o      (frame_i.ready),
    .in_seq_i        (frame_i.seq_num),
    .in_payload_i    (frame_i.payload),
    .out_valid_o     (result_o.valid),
    .out_ready_i     (result_o.ready),
    .out_kind_o      (result_o.kind),
    .out_number_o    (result_o.number),
    .out_data_o      (result_o.data_out),
    .out_with_data_o (result_o.with_data),
    .out_last_o      (result_o.last),
    .alu_op_o        (alu_op),
    .alu_a_o         (alu_a),
    .alu_b_o         (alu_b),
    .alu_res_i       (alu_res),
    .store_req_o     (store_req),
    .store_rsp_i     (store_rsp)
  );

  // Shared modulo unit.
  srrw_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  // Slot marks and payload buffer.
  srrw_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (store_req),
    .rsp_o  (store_rsp)
  );

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Selective-repeat receiver window testbench
// Sends data frames and mode writes to the receiver and predicts every ACK,
// NACK and delivery that it should return. Each taken result is compared
// field by field with the oldest prediction. Both channels idle at random,
// and the mode is changed only after all outstanding results have come back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import srrw_pkg::*;

  // The spare mode code is expected to behave like plain ACK mode.
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam int RANDOM_FRAMES = 357;
  localparam int DRAIN_CYCLES  = 8;
  localparam int TAIL_CYCLES   = 20;
  localparam int CYCLE_LIMIT   = 750000;
  localparam int MAX_REPORTS   = 10;

  // One planned request: either a frame or a write of the mode register.
  typedef struct {
    logic                    is_mode_write;
    logic [MODE_W-1:0]       mode;
    logic [SEQ_W-1:0]        seq;
    logic [PAYLOAD_BITS-1:0] payload;
  } plan_entry_t;

  // One predicted result.
  typedef struct {
    kind_e                   kind;
    logic [SEQ_W-1:0]        number;
    logic [PAYLOAD_BITS-1:0] data_out;
    logic                    with_data;
    logic                    last;
  } reply_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  srrw_frame_if  frame_bus();
  srrw_result_if result_bus();
  srrw_cfg_if    cfg_bus();

  selective_repeat_receiver_window DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .frame_i  (frame_bus),
    .result_o (result_bus),
    .cfg_i    (cfg_bus)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  plan_entry_t frame_plan[$];
  reply_t      awaited_results[$];

  // Receiver state as the predictor sees it.
  logic [MODE_W-1:0]       mode_q = MODE_ACK;
  logic [SEQ_W-1:0]        win_base = '0;
  logic                    slot_marked [WINDOW] = '{default: 1'b0};
  logic [PAYLOAD_BITS-1:0] slot_data   [WINDOW] = '{default: '0};

  int request_total = 0;
  int requests_done = 0;
  int fail_count    = 0;
  int cycle_count   = 0;

  logic        frame_taken;
  logic        mode_taken;
  logic        next_frame_valid;
  logic        next_mode_valid;
  plan_entry_t next_entry;
  int          send_gap;
  int          send_steady;
  int          idle_cycles;
  int          take_gap;
  int          take_steady;
  reply_t      want;

  // Draws an idle gap: mostly short, a few long, with stretches of none.
  function automatic int next_gap(inout int steady);
    int roll;
    if (steady > 0) begin
      steady--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) steady = $urandom_range(20, 60);
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void queue_reply(input kind_e kind, input logic [SEQ_W-1:0] number,
                                      input logic [PAYLOAD_BITS-1:0] data,
                                      input logic with_data);
    reply_t r;
    r.kind      = kind;
    r.number    = number;
    r.data_out  = data;
    r.with_data = with_data;
    r.last      = 1'b0;
    awaited_results.push_back(r);
  endfunction

  // Works out the results of one accepted frame and updates the window.
  function automatic void answer_frame(input logic [SEQ_W-1:0] seq,
                                       input logic [PAYLOAD_BITS-1:0] data);
    logic [SEQ_W-1:0]  base;
    logic [SEQ_W-1:0]  offset;
    logic [SLOT_W-1:0] slot;
    logic              piggy;
    int                depth0;
    depth0 = awaited_results.size();
    base   = win_base;
    offset = seq - base;
    piggy  = (mode_q == MODE_PIGGY);
    if (offset < WINDOW) begin
      // Inside the window: buffer, acknowledge, then deliver what is in order.
      slot = seq[SLOT_W-1:0];
      slot_data[slot]   = data;
      slot_marked[slot] = 1'b1;
      if (mode_q == MODE_NACK) begin
        queue_reply(KIND_ACK, seq, '0, 1'b0);
        if (offset != 0) queue_reply(KIND_NACK, base, '0, 1'b0);
      end else begin
        queue_reply(KIND_ACK, seq, '0, piggy);
      end
      for (int i = 0; i < WINDOW; i++) begin
        if (!slot_marked[base[SLOT_W-1:0]]) break;
        queue_reply(KIND_DELIVER, base, slot_data[base[SLOT_W-1:0]], 1'b0);
        slot_marked[base[SLOT_W-1:0]] = 1'b0;
        base = base + 1'b1;
      end
      win_base = base;
    end else if (SEQ_SPACE - int'(offset) <= WINDOW) begin
      // Duplicate just behind the window: acknowledge it again.
      queue_reply(KIND_ACK, seq, '0, piggy);
    end
    if (awaited_results.size() > depth0)
      awaited_results[awaited_results.size() - 1].last = 1'b1;
  endfunction

  function automatic void add_frame(input logic [SEQ_W-1:0] seq,
                                    input logic [PAYLOAD_BITS-1:0] payload);
    plan_entry_t e;
    e.is_mode_write = 1'b0;
    e.mode          = '0;
    e.seq           = seq;
    e.payload       = payload;
    frame_plan.push_back(e);
  endfunction

  function automatic void add_mode(input logic [MODE_W-1:0] mode);
    plan_entry_t e;
    e.is_mode_write = 1'b1;
    e.mode          = mode;
    e.seq           = '0;
    e.payload       = '0;
    frame_plan.push_back(e);
  endfunction

  // Request driver: frames and mode writes from the plan, with random gaps.
  // A mode write waits until every result is back and the block is quiet.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_bus.valid   <= 1'b0;
      frame_bus.seq_num <= '0;
      frame_bus.payload <= '0;
      cfg_bus.valid     <= 1'b0;
      cfg_bus.data      <= '0;
      send_gap    = 0;
      send_steady = 0;
      idle_cycles = 0;
    end else begin
      frame_taken = frame_bus.valid && frame_bus.ready;
      mode_taken  = cfg_bus.valid && cfg_bus.ready;
      if (frame_taken) begin
        answer_frame(frame_bus.seq_num, frame_bus.payload);
        requests_done++;
      end
      if (mode_taken) begin
        mode_q = cfg_bus.data;
        requests_done++;
      end
      idle_cycles = frame_bus.valid ? 0 : idle_cycles + 1;
      if (!((frame_bus.valid && !frame_taken) || (cfg_bus.valid && !mode_taken))) begin
        next_frame_valid = 1'b0;
        next_mode_valid  = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (frame_plan.size() != 0) begin
          if (frame_plan[0].is_mode_write) begin
            if (awaited_results.size() == 0 && idle_cycles >= DRAIN_CYCLES) begin
              next_entry = frame_plan.pop_front();
              cfg_bus.data    <= next_entry.mode;
              next_mode_valid  = 1'b1;
            end
          end else begin
            next_entry = frame_plan.pop_front();
            frame_bus.seq_num <= next_entry.seq;
            frame_bus.payload <= next_entry.payload;
            next_frame_valid   = 1'b1;
            send_gap           = next_gap(send_steady);
          end
        end
        frame_bus.valid <= next_frame_valid;
        cfg_bus.valid   <= next_mode_valid;
      end
    end
  end

  // Result monitor: random back-pressure and comparison with predictions.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_bus.ready <= 1'b0;
      take_gap    = 0;
      take_steady = 0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        if (awaited_results.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected result: kind %0d number %0d data %h with_data %0d last %0d",
                     result_bus.kind, result_bus.number, result_bus.data_out,
                     result_bus.with_data, result_bus.last);
        end else begin
          want = awaited_results.pop_front();
          if (result_bus.kind !== want.kind || result_bus.number !== want.number ||
              result_bus.data_out !== want.data_out ||
              result_bus.with_data !== want.with_data || result_bus.last !== want.last) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("mismatch: expected kind %0d number %0d data %h with_data %0d last %0d",
                       want.kind, want.number, want.data_out, want.with_data, want.last,
                       " / actual kind %0d number %0d data %h with_data %0d last %0d",
                       result_bus.kind, result_bus.number, result_bus.data_out,
                       result_bus.with_data, result_bus.last);
          end
        end
      end
      if (take_gap > 0) begin
        take_gap--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
        take_gap = next_gap(take_steady);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Stimulus plan, reset and end of run.
  initial begin
    logic [SEQ_W-1:0]  gen_base;
    logic [WINDOW-1:0] sent_mask;
    logic [SLOT_W-1:0] off;
    int                lowest;
    int                roll;
    int                phase_len;
    int                random_left;

    frame_bus.valid   = 1'b0;
    frame_bus.seq_num = '0;
    frame_bus.payload = '0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.data      = '0;
    result_bus.ready  = 1'b0;
    rst_ni            = 1'b0;

    // Plain ACK mode: delivery, duplicate behind the base, out-of-order
    // frames, a frame that releases four deliveries, duplicate at full
    // distance and a frame at the wrapped edge of the window.
    add_mode(MODE_ACK);
    add_frame(3'd0, 32'h0000_0000);
    add_frame(3'd0, 32'hFFFF_FFFF);
    add_frame(3'd4, 32'h1357_9BDF);
    add_frame(3'd3, 32'hAAAA_AAAA);
    add_frame(3'd2, 32'h5555_5555);
    add_frame(3'd1, 32'hFFFF_FFFF);
    add_frame(3'd1, 32'h0000_0000);
    add_frame(3'd0, 32'h0000_0001);
    // ACK plus NACK mode: frames ahead of the base draw a NACK.
    add_mode(MODE_NACK);
    add_frame(3'd6, 32'h1234_5678);
    add_frame(3'd5, 32'hDEAD_BEEF);
    add_frame(3'd7, 32'h8000_0000);
    add_frame(3'd4, 32'h7FFF_FFFF);
    // Piggyback mode, including a duplicate.
    add_mode(MODE_PIGGY);
    add_frame(3'd1, 32'h0F0F_0F0F);
    add_frame(3'd3, 32'hF0F0_F0F0);
    add_frame(3'd2, 32'h0000_0001);
    add_frame(3'd2, 32'h0000_0000);
    // Spare mode code, then close the window so that the base sits at four.
    add_mode(MODE_SPARE);
    add_frame(3'd6, 32'hFFFF_FFFF);
    add_frame(3'd5, 32'h0000_0000);
    add_frame(3'd7, 32'h0000_0000);
    add_frame(3'd3, 32'hC3C3_C3C3);
    add_frame(3'd0, 32'h3C3C_3C3C);
    add_frame(3'd1, 32'h0000_0000);
    add_frame(3'd2, 32'hFFFF_FFFF);

    // Random phases: mostly a sender filling its window out of order, with
    // retransmissions, duplicates behind the window and some stray frames.
    gen_base    = 3'd4;
    sent_mask   = '0;
    random_left = RANDOM_FRAMES;
    while (random_left > 0) begin
      add_mode(MODE_W'($urandom_range(MODE_ACK, MODE_SPARE)));
      phase_len = $urandom_range(40, 80);
      while (phase_len > 0 && random_left > 0) begin
        roll   = $urandom_range(0, 99);
        lowest = 0;
        while (sent_mask[lowest]) lowest++;
        if (roll < 75) begin
          do off = SLOT_W'($urandom_range(0, WINDOW - 1)); while (sent_mask[off]);
          add_frame(gen_base + SEQ_W'(off), $urandom);
          sent_mask[off] = 1'b1;
          if (&sent_mask) begin
            gen_base  = gen_base + SEQ_W'(WINDOW);
            sent_mask = '0;
          end
        end else if (roll < 90) begin
          if (sent_mask != 0 && (roll % 2) == 1) begin
            do off = SLOT_W'($urandom_range(0, WINDOW - 1)); while (!sent_mask[off]);
            add_frame(gen_base + SEQ_W'(off), $urandom);
          end else begin
            add_frame(gen_base - SEQ_W'($urandom_range(1, WINDOW - lowest)), $urandom);
          end
        end else begin
          add_frame(SEQ_W'($urandom_range(0, SEQ_SPACE - 1)), $urandom);
        end
        phase_len--;
        random_left--;
      end
    end
    request_total = frame_plan.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (requests_done != request_total) @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
